// File: hw/rtl/mesh_adjacency_laplacian_table_macros.svh
// Assertion macros used by malt_back.sv.
`ifndef MESH_ADJACENCY_LAPLACIAN_TABLE_MACROS_SVH
`define MESH_ADJACENCY_LAPLACIAN_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define MALT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MALT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MALT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MALT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: hw/rtl/malt_pkg.sv
package malt_pkg;
    localparam int MaxNeighbors = 32;
    localparam int VertexCount = 1024;
    localparam int VW = 10;
    localparam int SW = $clog2(MaxNeighbors);
    localparam int DW = $clog2(MaxNeighbors + 1);
    localparam int AW = $clog2(VertexCount);
    localparam logic [15:0] QOne = 16'd16384;
    localparam int QW = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t           op;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
    } cmd_t;

    // The magnitude is 16384 / d rounded to nearest.
    function automatic logic [15:0] weight_mag(input logic [DW-1:0] d);
        logic [15:0] r;
        unique case (d)
            6'd1:  r = 16'd16384;
            6'd2:  r = 16'd8192;
            6'd3:  r = 16'd5461;
            6'd4:  r = 16'd4096;
            6'd5:  r = 16'd3277;
            6'd6:  r = 16'd2731;
            6'd7:  r = 16'd2341;
            6'd8:  r = 16'd2048;
            6'd9:  r = 16'd1820;
            6'd10: r = 16'd1638;
            6'd11: r = 16'd1489;
            6'd12: r = 16'd1365;
            6'd13: r = 16'd1260;
            6'd14: r = 16'd1170;
            6'd15: r = 16'd1092;
            6'd16: r = 16'd1024;
            6'd17: r = 16'd964;
            6'd18: r = 16'd910;
            6'd19: r = 16'd862;
            6'd20: r = 16'd819;
            6'd21: r = 16'd780;
            6'd22: r = 16'd745;
            6'd23: r = 16'd712;
            6'd24: r = 16'd683;
            6'd25: r = 16'd655;
            6'd26: r = 16'd630;
            6'd27: r = 16'd607;
            6'd28: r = 16'd585;
            6'd29: r = 16'd565;
            6'd30: r = 16'd546;
            6'd31: r = 16'd529;
            6'd32: r = 16'd512;
            default: r = 16'd0;
        endcase
        return r;
    endfunction
endpackage

// File: hw/rtl/malt_front.sv
module malt_front
    import malt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // first_vertex, second_vertex
    input  logic [1:0]  s_tuser,  // op
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);
    cmd_t q_reg [QW];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;
    cmd_t c;

    always_comb
    begin
        c.op = op_t'(s_tuser);
        c.a = s_tdata[9:0];
        c.b = s_tdata[19:10];
    end

    assign s_tready = cnt_reg != 2'(QW);
    assign push = s_tvalid && s_tready && c.op != OP_NONE;
    assign q_valid = cnt_reg != 2'd0;
    assign pop = q_valid && q_ready;
    assign q_cmd = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: hw/rtl/malt_back.sv
`include "mesh_adjacency_laplacian_table_macros.svh"
module malt_back
    import malt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // column vertex, weight
    output logic [1:0]  m_tuser,  // is_self, row_empty
    output logic        m_tlast
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CLR   = 9'b000000010,
        ST_SCAN  = 9'b000000100,
        ST_APND  = 9'b000001000,
        ST_RDEG  = 9'b000010000,
        ST_RWAIT = 9'b000100000,
        ST_EMIT  = 9'b001000000,
        ST_SELF  = 9'b010000000,
        ST_EMPTY = 9'b100000000
    } st_t;

    logic [VW-1:0] slot_mem [VertexCount*MaxNeighbors];
    logic [DW-1:0] deg_mem [VertexCount];

    st_t st_reg, st_next;
    logic [AW-1:0] clr_reg;
    logic [VW-1:0] row_reg, nb_reg;
    logic          second_reg;
    logic          is_read_reg;
    logic [DW-1:0] deg_reg;
    logic [SW:0]   k_reg;
    logic          hit_reg;
    logic [VW-1:0] slot_q_reg;
    logic [DW-1:0] deg_q_reg;
    logic          rd_pend_reg;
    logic [15:0]   negw_reg;

    logic          ov_reg;
    logic [VW-1:0] o_idx_reg;
    logic [15:0]   o_w_reg;
    logic          o_self_reg, o_empty_reg, o_last_reg;

    logic [SW:0] shown;
    logic        can_out;
    logic        deg_we, slot_we, slot_re;
    logic [AW-1:0] deg_wa;
    logic [DW-1:0] deg_wd;
    logic [AW+SW-1:0] slot_wa, slot_ra;
    logic [AW-1:0] deg_ra;
    logic          out_load;
    logic [VW-1:0] out_idx;
    logic [15:0]   out_w;
    logic          out_self, out_empty, out_last;

    assign can_out = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata = {6'b0, o_w_reg, o_idx_reg};
    assign m_tuser = {o_empty_reg, o_self_reg};
    assign m_tlast = o_last_reg;
    assign shown = (deg_reg < DW'(MaxNeighbors - 1)) ? (SW+1)'(deg_reg)
                                                      : (SW+1)'(MaxNeighbors - 1);
    assign q_ready = st_reg == ST_IDLE;

    always_comb
    begin
        slot_ra = {row_reg[AW-1:0], k_reg[SW-1:0]};
        slot_re = 1'b0;
        slot_we = 1'b0;
        slot_wa = {row_reg[AW-1:0], deg_reg[SW-1:0]};
        deg_ra = row_reg[AW-1:0];
        deg_we = 1'b0;
        deg_wa = row_reg[AW-1:0];
        deg_wd = deg_reg + 1'b1;
        out_load = 1'b0;
        out_idx = '0;
        out_w = '0;
        out_self = 1'b0;
        out_empty = 1'b0;
        out_last = 1'b0;
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_INSERT: st_next = ST_RDEG;
                        OP_READ: st_next = ST_RDEG;
                        OP_CLEAR: st_next = ST_CLR;
                        default: st_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLR:
            begin
                deg_we = 1'b1;
                deg_wa = clr_reg;
                deg_wd = '0;
                if (clr_reg == AW'(VertexCount - 1)) st_next = ST_IDLE;
            end
            ST_RDEG: st_next = ST_RWAIT;
            ST_RWAIT:
            begin
                if (!is_read_reg) st_next = ST_SCAN;
                else if (deg_q_reg == '0) st_next = ST_EMPTY;
                else st_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                if (k_reg < (SW+1)'(deg_reg)) slot_re = 1'b1;
                else if (!rd_pend_reg) st_next = ST_APND;
            end
            ST_APND:
            begin
                if (!hit_reg && deg_reg < DW'(MaxNeighbors))
                begin
                    slot_we = 1'b1;
                    deg_we = 1'b1;
                end
                st_next = (second_reg || row_reg == nb_reg) ? ST_IDLE : ST_RDEG;
            end
            ST_EMIT:
            begin
                if (k_reg == shown && !rd_pend_reg)
                begin
                    st_next = ST_SELF;
                end
                else if (can_out || !rd_pend_reg)
                begin
                    out_load = rd_pend_reg;
                    out_idx = slot_q_reg;
                    out_w = negw_reg;
                    slot_re = k_reg != shown;
                end
            end
            ST_SELF:
            begin
                if (can_out)
                begin
                    out_load = 1'b1;
                    out_idx = row_reg;
                    out_w = QOne;
                    out_self = 1'b1;
                    out_last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (can_out)
                begin
                    out_load = 1'b1;
                    out_empty = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (deg_we) deg_mem[deg_wa] <= deg_wd;
        if (slot_we) slot_mem[slot_wa] <= nb_reg;
        deg_q_reg <= deg_mem[deg_ra];
        if (slot_re) slot_q_reg <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_CLR;
            clr_reg <= '0;
            row_reg <= '0;
            nb_reg <= '0;
            second_reg <= 1'b0;
            is_read_reg <= 1'b0;
            deg_reg <= '0;
            k_reg <= '0;
            hit_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            negw_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        row_reg <= q_cmd.a;
                        nb_reg <= q_cmd.b;
                        second_reg <= 1'b0;
                        is_read_reg <= q_cmd.op == OP_READ;
                    end
                end
                ST_CLR: clr_reg <= clr_reg + 1'b1;
                ST_RWAIT:
                begin
                    deg_reg <= deg_q_reg;
                    negw_reg <= 16'h0000 - weight_mag(deg_q_reg);
                    k_reg <= '0;
                    hit_reg <= 1'b0;
                    rd_pend_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (rd_pend_reg && slot_q_reg == nb_reg) hit_reg <= 1'b1;
                    if (slot_re)
                    begin
                        k_reg <= k_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                end
                ST_APND:
                begin
                    if (!(second_reg || row_reg == nb_reg))
                    begin
                        second_reg <= 1'b1;
                        row_reg <= nb_reg;
                        nb_reg <= row_reg;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_re)
                    begin
                        k_reg <= k_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else if (can_out || !rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            o_idx_reg <= '0;
            o_w_reg <= '0;
            o_self_reg <= 1'b0;
            o_empty_reg <= 1'b0;
            o_last_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ov_reg <= 1'b1;
            o_idx_reg <= out_idx;
            o_w_reg <= out_w;
            o_self_reg <= out_self;
            o_empty_reg <= out_empty;
            o_last_reg <= out_last;
        end
        else if (m_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    `MALT_ASSERT_IMPL(a_onehot, clk, rst_n, $onehot(st_reg), "state not one-hot")
    `MALT_ASSERT_IMPL(a_self_last, clk, rst_n, !m_tvalid || (o_self_reg == o_last_reg), "self/last")
    `MALT_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")
    `MALT_ASSERT_IMPL(a_empty, clk, rst_n, !(m_tvalid && o_empty_reg) || (o_idx_reg == '0 && !o_self_reg), "empty entry not zeroed")
endmodule

// File: hw/rtl/mesh_adjacency_laplacian_table.sv
// Channel  Dir  tdata fields (low bit up)                   tuser (low bit up)    tlast
// s        in   first_vertex[9:0] second_vertex[19:10]      op[1:0]               -
// m        out  column_vertex[9:0] weight[25:10]            is_self row_empty     last
// An insert walks each endpoint row through RDEG, RWAIT, SCAN and APND; a self loop
// walks its row once.
// A read emits shown entries, shown being the degree capped at 31, with one entry a
// cycle while the output is not stalled; an isolated vertex gives one empty item.
// After reset and after a clear op the degree table is swept while no item is started;
// items still queue in the two-entry front queue.
// A stalled output holds its item and stops the row walk.
module mesh_adjacency_laplacian_table
    import malt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // first_vertex, second_vertex
    input  logic [1:0]  s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // column_vertex, weight
    output logic [1:0]  m_tuser,  // is_self, row_empty
    output logic        m_tlast
);
    logic q_valid, q_ready;
    cmd_t q_cmd;

    malt_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd)
    );

    malt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import malt_pkg::*;

    typedef struct {
        logic [9:0]  nb;
        logic [15:0] w;
        logic        self_bit;
        logic        empty_bit;
        logic        last_bit;
    } entry_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic [9:0] row_table [0:1023][0:31];
    int         degree [0:1023];
    entry_t     pending_entries [$];
    int         errors;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         recv_hold;
    int         quiet_cycles;
    logic [9:0] hubs [0:3];

    mesh_adjacency_laplacian_table DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    function automatic void clear_rows();
        for (int v = 0; v < 1024; v++)
        begin
            degree[v] = 0;
        end
    endfunction

    function automatic void add_neighbor(int row, logic [9:0] nb);
        for (int k = 0; k < degree[row]; k++)
        begin
            if (row_table[row][k] == nb)
            begin
                return;
            end
        end
        if (degree[row] >= MaxNeighbors)
        begin
            return;
        end
        row_table[row][degree[row]] = nb;
        degree[row]++;
    endfunction

    function automatic void predict_laplacian(op_t op, logic [9:0] a, logic [9:0] b);
        entry_t e;
        int     d;
        int     shown;
        int     mag;
        case (op)
            OP_INSERT:
            begin
                add_neighbor(a, b);
                add_neighbor(b, a);
            end
            OP_CLEAR: clear_rows();
            OP_READ:
            begin
                d = degree[a];
                if (d == 0)
                begin
                    e = '{10'd0, 16'd0, 1'b0, 1'b1, 1'b0};
                    pending_entries.push_back(e);
                end
                else
                begin
                    mag = (16384 + d / 2) / d;
                    shown = (d < MaxNeighbors - 1) ? d : MaxNeighbors - 1;
                    for (int k = 0; k < shown; k++)
                    begin
                        e = '{row_table[a][k], 16'(-mag), 1'b0, 1'b0, 1'b0};
                        pending_entries.push_back(e);
                    end
                    e = '{a, QOne, 1'b1, 1'b0, 1'b1};
                    pending_entries.push_back(e);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_item(op_t op, logic [9:0] a, logic [9:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, b, a};
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_laplacian(op, a, b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_entries.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        entry_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_entries.size() == 0)
            begin
                $display("%0t: unexpected item, actual %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                e = pending_entries.pop_front();
                if (m_tdata[9:0] !== e.nb || m_tdata[25:10] !== e.w
                    || m_tuser[0] !== e.self_bit || m_tuser[1] !== e.empty_bit
                    || m_tlast !== e.last_bit || m_tdata[31:26] !== 6'd0)
                begin
                    $display("%0t: mismatch, expected nb %0d w %h self %b empty %b last %b,",
                             $time, e.nb, e.w, e.self_bit, e.empty_bit, e.last_bit);
                    $display("    actual nb %0d w %h self %b empty %b last %b",
                             m_tdata[9:0], m_tdata[25:10], m_tuser[0], m_tuser[1], m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles > 20000)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        send_item(OP_READ, 10'd0, 10'd0);
        send_item(OP_INSERT, 10'd0, 10'd1023);
        send_item(OP_INSERT, 10'd0, 10'd1023);
        send_item(OP_INSERT, 10'd5, 10'd5);
        send_item(OP_INSERT, 10'd0, 10'd5);
        send_item(OP_READ, 10'd0, 10'h3ff);
        send_item(OP_READ, 10'd1023, 10'd0);
        send_item(OP_READ, 10'd5, 10'd0);
        send_item(OP_NONE, 10'd5, 10'd7);
        send_item(OP_READ, 10'd5, 10'h2aa);
        for (int k = 1; k <= 34; k++)
        begin
            send_item(OP_INSERT, 10'd700, 10'(k + 100));
            if (k == 30 || k == 31)
            begin
                send_item(OP_READ, 10'd700, 10'd0);
            end
        end
        send_item(OP_READ, 10'd700, 10'd0);
        send_item(OP_READ, 10'd101, 10'd0);
        send_item(OP_CLEAR, 10'h155, 10'h2aa);
        send_item(OP_READ, 10'd700, 10'd0);
        drain();
    endtask

    task automatic test_random(int count);
        int   pick;
        op_t  op;
        logic [9:0] a;
        logic [9:0] b;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            a = (pick & 1) ? hubs[$urandom_range(3)] : 10'($urandom_range(1023));
            b = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                         : 10'($urandom_range(hubs[0] + 40, hubs[0]));
            if (pick < 55)
            begin
                op = OP_INSERT;
            end
            else if (pick < 95)
            begin
                op = OP_READ;
                if ($urandom_range(2) != 0)
                begin
                    a = hubs[$urandom_range(3)];
                end
            end
            else if (pick < 97)
            begin
                op = OP_CLEAR;
            end
            else
            begin
                op = OP_NONE;
            end
            send_item(op, a, b);
        end
        drain();
    endtask

    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            begin
                for (int k = 0; k < 6; k++)
                begin
                    send_item(OP_READ, hubs[k % 4], 10'd0);
                end
            end
        join
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        recv_hold = 1'b0;
        quiet_cycles = 0;
        clear_rows();
        for (int k = 0; k < 4; k++)
        begin
            hubs[k] = 10'($urandom_range(980));
        end
        send_idle_pct = 16;
        recv_idle_pct = 46;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(55);
        send_idle_pct = 46;
        recv_idle_pct = 16;
        test_random(55);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(55);
        test_backpressure();
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
